[rtl/iee_pkg.sv]
// Package with shared types, codes and constants of the infix expression evaluator.
`default_nettype none
package iee_pkg;
	localparam int unsigned MaxOperatorsDefault = 99;
	localparam int unsigned NumVars = 26;
	localparam int unsigned VarIdxW = 5;
	localparam int unsigned DataW = 32;
	localparam int unsigned OpCountW = 7;
	localparam int unsigned FifoDepth = 2;

	typedef enum logic [2:0] {
		ERR_NONE = 3'd0,
		ERR_MISPLACED_OP = 3'd1,
		ERR_MISPLACED_VAR = 3'd2,
		ERR_UNKNOWN_CHAR = 3'd3,
		ERR_TOO_MANY_OPS = 3'd4,
		ERR_INCOMPLETE = 3'd5,
		ERR_DIV_ZERO = 3'd6
	} err_t;

	typedef enum logic [2:0] {
		CLS_SPACE,
		CLS_DIGIT,
		CLS_ALPHA,
		CLS_ADD,
		CLS_SUB,
		CLS_MUL,
		CLS_DIV,
		CLS_OTHER
	} cls_t;

	typedef enum logic [1:0] {
		SCAN_START = 2'd0,
		SCAN_NUMBER = 2'd1,
		SCAN_AFTER_OP = 2'd2,
		SCAN_AFTER_VAR = 2'd3
	} scan_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_FIRST = 2'd1,
		OP_SECOND = 2'd2
	} pend_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FOLD_OPND,
		ST_DIV,
		ST_FOLD_TERM,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic is_write;
		logic last;
		cls_t cls;
		logic [3:0] digit;
		logic [VarIdxW-1:0] var_index;
		logic [DataW-1:0] var_value;
	} cmd_t;

	function automatic cls_t classify(input logic [7:0] ch);
		cls_t c;
		c = CLS_OTHER;
		if (ch == 8'h20) c = CLS_SPACE;
		else if (ch >= 8'h30 && ch <= 8'h39) c = CLS_DIGIT;
		else if ((ch >= 8'h41 && ch <= 8'h5a) || (ch >= 8'h61 && ch <= 8'h7a)) c = CLS_ALPHA;
		else if (ch == 8'h2b) c = CLS_ADD;
		else if (ch == 8'h2d) c = CLS_SUB;
		else if (ch == 8'h2a) c = CLS_MUL;
		else if (ch == 8'h2f) c = CLS_DIV;
		return c;
	endfunction
endpackage
`default_nettype wire

[rtl/iee_stream_if.sv]
// Valid and ready channel interface with a generic payload.
`default_nettype none
interface iee_stream_if #(
	parameter type payload_t = logic
);
	logic valid;
	logic ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/infix_expression_evaluator_core.sv]
// Top level of the streaming infix expression evaluator.
// The input channel (in_valid, in_ready) moves one item per transfer. With req_type
// low the item is an expression character (char_code, last); with req_type high it
// writes var_value into the variable table at var_index, and an index above 25 is
// ignored. A table write never gives a result.
// The output channel (out_valid, out_ready) moves result and error_code, one transfer
// for every character marked last.
// A two-entry queue separates the front end from the back end. The back end takes a
// digit, letter or space while idle, * or / through the operand fold, + or - through
// the operand and term folds; a division adds a divider run. After the last character
// a result passes the operand fold, any divider run, the term fold and the finish
// state, or only the finish state on an error or an incomplete expression.
// While a result waits for out_ready the back end holds the next result, the queue
// fills and in_ready drops until the receiver takes the waiting one.
// Reset clears the queue and the expression state and marks every variable table entry
// unwritten, so it reads as zero; in_ready is high in the first cycle after reset.
`default_nettype none
module infix_expression_evaluator_core #(
	parameter int unsigned MAX_OPERATORS = iee_pkg::MaxOperatorsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic req_type,
	input wire logic [7:0] char_code,
	input wire logic last,
	input wire logic [iee_pkg::VarIdxW-1:0] var_index,
	input wire logic [iee_pkg::DataW-1:0] var_value,
	output logic out_valid,
	input wire logic out_ready,
	output logic [iee_pkg::DataW-1:0] result,
	output logic [2:0] error_code
);
	logic cmd_valid, cmd_ready;
	iee_pkg::cmd_t cmd;

	iee_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.in_req_type(req_type), .in_char_code(char_code), .in_last(last),
		.in_var_index(var_index), .in_var_value(var_value),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	iee_back #(.MAX_OPERATORS(MAX_OPERATORS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_result(result), .out_error_code(error_code)
	);
endmodule
`default_nettype wire

[rtl/iee_front.sv]
// Front end: accepts items, classifies characters and queues commands.
`default_nettype none
module iee_front (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic in_req_type,
	input wire logic [7:0] in_char_code,
	input wire logic in_last,
	input wire logic [iee_pkg::VarIdxW-1:0] in_var_index,
	input wire logic [iee_pkg::DataW-1:0] in_var_value,
	output logic cmd_valid,
	input wire logic cmd_ready,
	output iee_pkg::cmd_t cmd
);
	iee_pkg::cmd_t fifo_q [iee_pkg::FifoDepth];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	iee_pkg::cmd_t new_cmd;
	logic push, pop;
	logic [7:0] up;

	always_comb begin
		up = in_char_code & 8'hdf;
		new_cmd.is_write = in_req_type;
		new_cmd.last = in_last;
		new_cmd.cls = iee_pkg::classify(in_char_code);
		new_cmd.digit = in_char_code[3:0];
		new_cmd.var_index = in_req_type ? in_var_index : 5'(up - 8'h41);
		new_cmd.var_value = in_var_value;
	end

	assign in_ready = (count_q != 2'd2);
	assign push = in_valid && in_ready;
	assign cmd_valid = (count_q != 2'd0);
	assign pop = cmd_valid && cmd_ready;
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= new_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end
endmodule
`default_nettype wire

[rtl/iee_divider.sv]
// Iterative signed divider truncating toward zero, one quotient bit a cycle.
`default_nettype none
module iee_divider (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic [iee_pkg::DataW-1:0] dividend,
	input wire logic [iee_pkg::DataW-1:0] divisor,
	output logic done,
	output logic [iee_pkg::DataW-1:0] quotient
);
	localparam int unsigned W = iee_pkg::DataW;
	logic [W-1:0] rem_q, quo_q, div_q;
	logic neg_q, busy_q, fin_q;
	logic [$clog2(W)-1:0] cnt_q;
	logic [W:0] trial;
	logic [W-1:0] rem_shift;

	always_comb begin
		rem_shift = {rem_q[W-2:0], quo_q[W-1]};
		trial = {1'b0, rem_shift} - {1'b0, div_q};
	end

	assign done = fin_q;
	assign quotient = neg_q ? (W)'(0) - quo_q : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			fin_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(W))'(W-1)) begin
					busy_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[W-1] ? (W)'(0) - dividend : dividend;
			div_q <= divisor[W-1] ? (W)'(0) - divisor : divisor;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_shift;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

[rtl/iee_back.sv]
// Back end: variable table, expression scan state and result register.
`default_nettype none
module iee_back #(
	parameter int unsigned MAX_OPERATORS = iee_pkg::MaxOperatorsDefault
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_ready,
	input wire iee_pkg::cmd_t cmd,
	output logic out_valid,
	input wire logic out_ready,
	output logic [iee_pkg::DataW-1:0] out_result,
	output logic [2:0] out_error_code
);
	localparam int unsigned W = iee_pkg::DataW;
	logic [W-1:0] vars_q [iee_pkg::NumVars];
	logic [iee_pkg::NumVars-1:0] vvalid_q;
	iee_pkg::state_t state_q, state_d, after_opnd;
	iee_pkg::scan_t scan_q, scan_d;
	iee_pkg::pend_t add_q, mul_q, mul_after;
	logic [W-1:0] sum_q, term_q, opnd_q, opnd_d;
	logic [iee_pkg::OpCountW-1:0] opcnt_q;
	iee_pkg::err_t err_q, err_d;
	logic [W-1:0] res_q;
	logic [2:0] rcode_q;
	logic ovalid_q;
	logic div_start, div_done;
	logic [W-1:0] div_quo;
	iee_pkg::cls_t op_cls_q;
	logic final_q;
	logic ch_ok, is_op, do_op, fin, end_incomplete;
	logic [W-1:0] var_rd;

	iee_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(term_q), .divisor(opnd_q),
		.done(div_done), .quotient(div_quo)
	);

	assign out_valid = ovalid_q;
	assign out_result = res_q;
	assign out_error_code = rcode_q;
	assign cmd_ready = (state_q == iee_pkg::ST_IDLE);

	always_comb begin
		var_rd = vvalid_q[cmd.var_index] ? vars_q[cmd.var_index] : '0;
		is_op = cmd.cls == iee_pkg::CLS_ADD || cmd.cls == iee_pkg::CLS_SUB ||
			cmd.cls == iee_pkg::CLS_MUL || cmd.cls == iee_pkg::CLS_DIV;
		ch_ok = err_q == iee_pkg::ERR_NONE || err_q == iee_pkg::ERR_DIV_ZERO;
		scan_d = scan_q;
		opnd_d = opnd_q;
		err_d = err_q;
		do_op = 1'b0;
		if (ch_ok) begin
			if (opcnt_q >= iee_pkg::OpCountW'(MAX_OPERATORS)) err_d = iee_pkg::ERR_TOO_MANY_OPS;
			else if (cmd.cls != iee_pkg::CLS_SPACE) begin
				case (scan_q)
					iee_pkg::SCAN_START, iee_pkg::SCAN_AFTER_OP: begin
						if (is_op) err_d = iee_pkg::ERR_MISPLACED_OP;
						else if (cmd.cls == iee_pkg::CLS_DIGIT) begin
							opnd_d = W'(cmd.digit);
							scan_d = iee_pkg::SCAN_NUMBER;
						end else if (cmd.cls == iee_pkg::CLS_ALPHA) begin
							opnd_d = var_rd;
							scan_d = iee_pkg::SCAN_AFTER_VAR;
						end else err_d = iee_pkg::ERR_UNKNOWN_CHAR;
					end
					iee_pkg::SCAN_NUMBER: begin
						if (is_op) do_op = 1'b1;
						else if (cmd.cls == iee_pkg::CLS_DIGIT)
							opnd_d = (opnd_q << 3) + (opnd_q << 1) + W'(cmd.digit);
						else if (cmd.cls == iee_pkg::CLS_ALPHA) err_d = iee_pkg::ERR_MISPLACED_VAR;
						else err_d = iee_pkg::ERR_UNKNOWN_CHAR;
					end
					default: begin
						if (is_op) do_op = 1'b1;
						else if (cmd.cls == iee_pkg::CLS_ALPHA) err_d = iee_pkg::ERR_MISPLACED_VAR;
						else err_d = iee_pkg::ERR_UNKNOWN_CHAR;
					end
				endcase
			end
		end
		if (do_op) scan_d = iee_pkg::SCAN_AFTER_OP;
		end_incomplete = (err_d == iee_pkg::ERR_NONE || err_d == iee_pkg::ERR_DIV_ZERO) &&
			(scan_d == iee_pkg::SCAN_START || scan_d == iee_pkg::SCAN_AFTER_OP);

		if (final_q || op_cls_q == iee_pkg::CLS_ADD || op_cls_q == iee_pkg::CLS_SUB)
			after_opnd = iee_pkg::ST_FOLD_TERM;
		else
			after_opnd = iee_pkg::ST_IDLE;
		if (final_q) mul_after = iee_pkg::OP_NONE;
		else if (op_cls_q == iee_pkg::CLS_MUL) mul_after = iee_pkg::OP_FIRST;
		else if (op_cls_q == iee_pkg::CLS_DIV) mul_after = iee_pkg::OP_SECOND;
		else mul_after = iee_pkg::OP_NONE;

		div_start = (state_q == iee_pkg::ST_FOLD_OPND) && (mul_q == iee_pkg::OP_SECOND) &&
			(opnd_q != '0);
		fin = (state_q == iee_pkg::ST_FINISH) && (!ovalid_q || out_ready);

		state_d = state_q;
		unique case (state_q)
			iee_pkg::ST_IDLE: begin
				if (cmd_valid && !cmd.is_write) begin
					if (cmd.last) begin
						if (!(err_d == iee_pkg::ERR_NONE || err_d == iee_pkg::ERR_DIV_ZERO) ||
							end_incomplete)
							state_d = iee_pkg::ST_FINISH;
						else
							state_d = iee_pkg::ST_FOLD_OPND;
					end else if (do_op) state_d = iee_pkg::ST_FOLD_OPND;
				end
			end
			iee_pkg::ST_FOLD_OPND: state_d = div_start ? iee_pkg::ST_DIV : after_opnd;
			iee_pkg::ST_DIV: if (div_done) state_d = after_opnd;
			iee_pkg::ST_FOLD_TERM: state_d = final_q ? iee_pkg::ST_FINISH : iee_pkg::ST_IDLE;
			iee_pkg::ST_FINISH: if (fin) state_d = iee_pkg::ST_IDLE;
			default: state_d = iee_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= iee_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (state_q == iee_pkg::ST_IDLE && cmd_valid && cmd.is_write &&
			cmd.var_index < iee_pkg::VarIdxW'(iee_pkg::NumVars))
			vars_q[cmd.var_index] <= cmd.var_value;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vvalid_q <= '0;
			scan_q <= iee_pkg::SCAN_START;
			add_q <= iee_pkg::OP_NONE;
			mul_q <= iee_pkg::OP_NONE;
			sum_q <= '0; term_q <= '0; opnd_q <= '0;
			opcnt_q <= '0;
			err_q <= iee_pkg::ERR_NONE;
			ovalid_q <= 1'b0;
			op_cls_q <= iee_pkg::CLS_SPACE;
			final_q <= 1'b0;
			res_q <= '0; rcode_q <= '0;
		end else begin
			if (fin) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			if (state_q == iee_pkg::ST_IDLE) begin
				if (cmd_valid) begin
					if (cmd.is_write) begin
						if (cmd.var_index < iee_pkg::VarIdxW'(iee_pkg::NumVars))
							vvalid_q[cmd.var_index] <= 1'b1;
					end else begin
						scan_q <= scan_d;
						opnd_q <= opnd_d;
						op_cls_q <= cmd.cls;
						final_q <= cmd.last;
						if (do_op) opcnt_q <= opcnt_q + 1'b1;
						if (cmd.last && end_incomplete) err_q <= iee_pkg::ERR_INCOMPLETE;
						else err_q <= err_d;
					end
				end
			end else if (state_q == iee_pkg::ST_FOLD_OPND) begin
				if (mul_q == iee_pkg::OP_FIRST) begin
					term_q <= term_q * opnd_q;
					mul_q <= mul_after;
				end else if (mul_q == iee_pkg::OP_SECOND) begin
					if (opnd_q == '0) begin
						if (err_q == iee_pkg::ERR_NONE) err_q <= iee_pkg::ERR_DIV_ZERO;
						mul_q <= mul_after;
					end
				end else begin
					term_q <= opnd_q;
					mul_q <= mul_after;
				end
			end else if (state_q == iee_pkg::ST_DIV) begin
				if (div_done) begin
					term_q <= div_quo;
					mul_q <= mul_after;
				end
			end else if (state_q == iee_pkg::ST_FOLD_TERM) begin
				sum_q <= add_q == iee_pkg::OP_FIRST ? sum_q + term_q :
					add_q == iee_pkg::OP_SECOND ? sum_q - term_q : term_q;
				if (final_q) add_q <= iee_pkg::OP_NONE;
				else add_q <= (op_cls_q == iee_pkg::CLS_ADD) ? iee_pkg::OP_FIRST :
					iee_pkg::OP_SECOND;
			end else if (fin) begin
				rcode_q <= err_q;
				res_q <= (err_q == iee_pkg::ERR_NONE) ? sum_q : '0;
				scan_q <= iee_pkg::SCAN_START;
				add_q <= iee_pkg::OP_NONE; mul_q <= iee_pkg::OP_NONE;
				sum_q <= '0; term_q <= '0; opnd_q <= '0; opcnt_q <= '0;
				err_q <= iee_pkg::ERR_NONE;
				final_q <= 1'b0;
			end
		end
	end
endmodule
`default_nettype wire

[sim/infix_expression_evaluator_core_test.sv]
// Self-checking testbench of the streaming infix expression evaluator core.
`default_nettype none
module infix_expression_evaluator_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned StallLimit = 3000;

	typedef struct packed {
		logic req_type;
		logic [7:0] char_code;
		logic last;
		logic [iee_pkg::VarIdxW-1:0] var_index;
		logic [iee_pkg::DataW-1:0] var_value;
	} expr_req_t;

	typedef struct packed {
		logic [iee_pkg::DataW-1:0] value;
		logic [2:0] code;
	} expr_res_t;

	logic clk;
	logic arst_n;
	iee_stream_if #(.payload_t(expr_req_t)) req_ch();
	iee_stream_if #(.payload_t(expr_res_t)) res_ch();
	logic [iee_pkg::DataW-1:0] dut_result;
	logic [2:0] dut_error;

	assign res_ch.data = {dut_result, dut_error};

	infix_expression_evaluator_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(req_ch.valid),
		.in_ready(req_ch.ready),
		.req_type(req_ch.data.req_type),
		.char_code(req_ch.data.char_code),
		.last(req_ch.data.last),
		.var_index(req_ch.data.var_index),
		.var_value(req_ch.data.var_value),
		.out_valid(res_ch.valid),
		.out_ready(res_ch.ready),
		.result(dut_result),
		.error_code(dut_error)
	);

	// Predictor state.
	logic [iee_pkg::DataW-1:0] var_table [iee_pkg::NumVars];
	iee_pkg::scan_t scan;
	logic [iee_pkg::DataW-1:0] sum_acc;
	logic [iee_pkg::DataW-1:0] term_acc;
	logic [iee_pkg::DataW-1:0] operand;
	iee_pkg::pend_t add_pend;
	iee_pkg::pend_t mul_pend;
	logic [iee_pkg::OpCountW-1:0] op_count;
	iee_pkg::err_t held_error;

	expr_res_t expected_results[$];
	bit failed = 0;
	bit sender_gaps = 1;
	bit receiver_stalls = 1;
	int unsigned receiver_hold = 0;
	int unsigned items_sent = 0;
	int unsigned idle_cycles = 0;

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	task automatic clear_expression();
		scan = iee_pkg::SCAN_START;
		sum_acc = '0;
		term_acc = '0;
		operand = '0;
		add_pend = iee_pkg::OP_NONE;
		mul_pend = iee_pkg::OP_NONE;
		op_count = '0;
		held_error = iee_pkg::ERR_NONE;
	endtask

	task automatic fold_operand();
		logic [iee_pkg::DataW-1:0] mag_a;
		logic [iee_pkg::DataW-1:0] mag_b;
		logic [iee_pkg::DataW-1:0] quot;
		if (mul_pend == iee_pkg::OP_FIRST) begin
			term_acc = term_acc * operand;
		end else if (mul_pend == iee_pkg::OP_SECOND) begin
			if (operand == 0) begin
				if (held_error == iee_pkg::ERR_NONE) held_error = iee_pkg::ERR_DIV_ZERO;
			end else begin
				mag_a = term_acc[31] ? -term_acc : term_acc;
				mag_b = operand[31] ? -operand : operand;
				quot = mag_a / mag_b;
				term_acc = (term_acc[31] != operand[31]) ? -quot : quot;
			end
		end else begin
			term_acc = operand;
		end
		mul_pend = iee_pkg::OP_NONE;
	endtask

	task automatic fold_term();
		if (add_pend == iee_pkg::OP_FIRST) sum_acc = sum_acc + term_acc;
		else if (add_pend == iee_pkg::OP_SECOND) sum_acc = sum_acc - term_acc;
		else sum_acc = term_acc;
		add_pend = iee_pkg::OP_NONE;
	endtask

	task automatic predict_result(input expr_req_t it);
		logic [7:0] ch;
		bit is_op;
		bit is_dig;
		bit is_alpha;
		iee_pkg::err_t fin;
		expr_res_t r;
		ch = it.char_code;
		if (it.req_type) begin
			if (it.var_index < iee_pkg::NumVars) var_table[it.var_index] = it.var_value;
			return;
		end
		is_op = (ch == "+") || (ch == "-") || (ch == "*") || (ch == "/");
		is_dig = (ch >= "0") && (ch <= "9");
		is_alpha = ((ch >= "A") && (ch <= "Z")) || ((ch >= "a") && (ch <= "z"));
		if (held_error == iee_pkg::ERR_NONE || held_error == iee_pkg::ERR_DIV_ZERO) begin
			if (op_count >= iee_pkg::MaxOperatorsDefault) begin
				held_error = iee_pkg::ERR_TOO_MANY_OPS;
			end else if (ch == " ") begin
			end else if (scan == iee_pkg::SCAN_START || scan == iee_pkg::SCAN_AFTER_OP) begin
				if (is_op) begin
					held_error = iee_pkg::ERR_MISPLACED_OP;
				end else if (is_dig) begin
					operand = iee_pkg::DataW'(ch - "0");
					scan = iee_pkg::SCAN_NUMBER;
				end else if (is_alpha) begin
					operand = var_table[(ch & 8'hDF) - "A"];
					scan = iee_pkg::SCAN_AFTER_VAR;
				end else begin
					held_error = iee_pkg::ERR_UNKNOWN_CHAR;
				end
			end else if (is_op) begin
				fold_operand();
				if (ch == "*") begin
					mul_pend = iee_pkg::OP_FIRST;
				end else if (ch == "/") begin
					mul_pend = iee_pkg::OP_SECOND;
				end else begin
					fold_term();
					add_pend = (ch == "+") ? iee_pkg::OP_FIRST : iee_pkg::OP_SECOND;
				end
				op_count = op_count + 1;
				scan = iee_pkg::SCAN_AFTER_OP;
			end else if (is_dig && scan == iee_pkg::SCAN_NUMBER) begin
				operand = operand * 10 + iee_pkg::DataW'(ch - "0");
			end else if (is_alpha) begin
				held_error = iee_pkg::ERR_MISPLACED_VAR;
			end else begin
				held_error = iee_pkg::ERR_UNKNOWN_CHAR;
			end
		end
		if (!it.last) return;
		fin = held_error;
		if (fin == iee_pkg::ERR_NONE || fin == iee_pkg::ERR_DIV_ZERO) begin
			if (scan == iee_pkg::SCAN_START || scan == iee_pkg::SCAN_AFTER_OP) begin
				fin = iee_pkg::ERR_INCOMPLETE;
			end else begin
				fold_operand();
				fold_term();
				fin = held_error;
			end
		end
		r.value = (fin != iee_pkg::ERR_NONE) ? '0 : sum_acc;
		r.code = fin;
		expected_results.push_back(r);
		clear_expression();
	endtask

	task automatic send_item(input expr_req_t it);
		req_ch.valid <= 1'b1;
		req_ch.data <= it;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predict_result(it);
		items_sent++;
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic send_char(input logic [7:0] ch, input bit is_last);
		expr_req_t it;
		it = '0;
		it.char_code = ch;
		it.last = is_last;
		it.var_index = iee_pkg::VarIdxW'($urandom);
		it.var_value = $urandom;
		send_item(it);
	endtask

	task automatic send_write(input logic [iee_pkg::VarIdxW-1:0] idx,
		input logic [iee_pkg::DataW-1:0] val);
		expr_req_t it;
		it = '0;
		it.req_type = 1'b1;
		it.var_index = idx;
		it.var_value = val;
		it.char_code = 8'($urandom);
		it.last = 1'($urandom);
		send_item(it);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
	endtask

	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic send_random_expression();
		byte unsigned text[$];
		int unsigned n_terms;
		int unsigned n_dig;
		n_terms = $urandom_range(1, 6);
		for (int t = 0; t < n_terms; t++) begin
			if ($urandom_range(0, 4) == 0) text.push_back(" ");
			if ($urandom_range(0, 9) < 3) begin
				text.push_back(8'($urandom_range(0, 1) ? "a" : "A") + 8'($urandom_range(0, 25)));
			end else if ($urandom_range(0, 7) == 0) begin
				text.push_back("0");
			end else begin
				n_dig = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 11) : $urandom_range(1, 3);
				for (int d = 0; d < n_dig; d++) text.push_back("0" + 8'($urandom_range(0, 9)));
			end
			if ($urandom_range(0, 4) == 0) text.push_back(" ");
			if (t != n_terms - 1) begin
				case ($urandom_range(0, 3))
					0: text.push_back("+");
					1: text.push_back("-");
					2: text.push_back("*");
					default: text.push_back("/");
				endcase
			end
		end
		if ($urandom_range(0, 5) == 0)
			text.insert($urandom_range(0, text.size()), 8'($urandom_range(0, 255)));
		if ($urandom_range(0, 11) == 0) text.push_back("+");
		for (int i = 0; i < text.size(); i++) send_char(text[i], i == text.size() - 1);
	endtask

	task automatic test_directed();
		send_write(0, 5);
		send_write(1, -7);
		send_write(25, 32'h8000_0000);
		send_write(24, 32'hFFFF_FFFF);
		send_write(5'd31, 32'h1234_5678);
		send_text("1+2*3");
		send_text("A*b - 3");
		send_text("z/y");
		send_text("7/-2");
		send_text("-7 / 2");
		send_text("1 2 3*a");
		send_text("2147483647+1");
		send_text("99999999999");
		send_text("7/0");
		send_text("7/0+");
		send_text("8/0*1-a1");
		send_text("+1");
		send_text("1+*2");
		send_text("a3");
		send_text("1a");
		send_text("a b");
		send_text("1#2");
		send_char(8'hFF, 1'b1);
		send_text(" ");
		send_text("1+");
		for (int i = 0; i < iee_pkg::MaxOperatorsDefault; i++) begin
			send_char("1", 1'b0);
			send_char("+", 1'b0);
		end
		send_text("1");
		for (int i = 0; i < iee_pkg::MaxOperatorsDefault - 1; i++) begin
			send_char("2", 1'b0);
			send_char("*", 1'b0);
		end
		send_text("1");
	endtask

	task automatic test_random();
		while (items_sent < 560) begin
			sender_gaps = $urandom_range(0, 3) != 0;
			receiver_stalls = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 2) == 0)
				repeat ($urandom_range(1, 3)) send_write(iee_pkg::VarIdxW'($urandom), $urandom);
			send_random_expression();
		end
	endtask

	task automatic test_backpressure();
		sender_gaps = 0;
		receiver_hold = 300;
		repeat (6) send_text("12*3");
		wait_drained();
	endtask

	task automatic test_final_stretch();
		sender_gaps = 0;
		receiver_stalls = 0;
		repeat (4) send_random_expression();
		req_ch.valid <= 1'b0;
	endtask

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > StallLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(posedge clk) begin
		expr_res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result %0d code %0d", $time, $signed(dut_result),
					dut_error);
				failed = 1;
			end else begin
				want = expected_results.pop_front();
				if (want.value !== dut_result) begin
					$display("%0t: result expected %0d actual %0d", $time, $signed(want.value),
						$signed(dut_result));
					failed = 1;
				end
				if (want.code !== dut_error) begin
					$display("%0t: error_code expected %0d actual %0d", $time, want.code,
						dut_error);
					failed = 1;
				end
			end
		end
	end

	initial begin
		res_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (receiver_hold != 0) begin
				res_ch.ready <= 1'b0;
				repeat (receiver_hold) @(posedge clk);
				receiver_hold = 0;
			end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data = '0;
		for (int i = 0; i < iee_pkg::NumVars; i++) var_table[i] = '0;
		clear_expression();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		wait_drained();
		test_backpressure();
		test_random();
		test_final_stretch();
		while (expected_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (!failed) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
rtl/iee_pkg.sv
rtl/iee_stream_if.sv
rtl/iee_front.sv
rtl/iee_divider.sv
rtl/iee_back.sv
rtl/infix_expression_evaluator_core.sv
sim/infix_expression_evaluator_core_test.sv
